### rtl/frd_pkg.sv
// ----------------------------------------------------------------------------
// frd_pkg
// Shared types and constants for the frame receiver with in-flight decryption.
// ----------------------------------------------------------------------------
package frd_pkg;

   localparam logic [15:0] DECRYPT_CLAMP       = 16'hFFFF;
   localparam logic [15:0] HEADER_BYTES        = 16'd3;
   localparam logic [15:0] MAX_BODY_RESET      = 16'd8192;

   localparam logic [1:0]  STATUS_HEADER       = 2'd0;
   localparam logic [1:0]  STATUS_BODY         = 2'd1;
   localparam logic [1:0]  STATUS_EMPTY        = 2'd2;
   localparam logic [1:0]  STATUS_LENGTH_ERROR = 2'd3;

   typedef struct packed {
      logic       valid;
      logic [7:0] rx_byte;
   } in_beat_type;

   typedef struct packed {
      logic [1:0]  status;
      logic [7:0]  data_byte;
      logic        last_of_message;
      logic [7:0]  message_key;
      logic [15:0] message_length;
   } rsp_type;

endpackage

### rtl/frd_in_stage.sv
// ----------------------------------------------------------------------------
// frd_in_stage
// Input register: holds one received beat until the decode stage takes it.
// ----------------------------------------------------------------------------
module frd_in_stage
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        out_ready,
   output in_beat_type beat
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       take;

   assign req_tready = !valid_ff || out_ready;
   assign take       = req_tvalid && req_tready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (take) begin
         valid_in = 1'b1;
         byte_in  = req_tdata;
      end else if (out_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign beat.valid   = valid_ff;
   assign beat.rx_byte = byte_ff;

endmodule

### rtl/frd_core.sv
// ----------------------------------------------------------------------------
// frd_core
// Header parser, body counter and per-byte decryption for one beat per cycle when not stalled.
// ----------------------------------------------------------------------------
module frd_core
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  in_beat_type beat,
   input  logic        out_ready,
   output logic        load,
   output rsp_type     rsp
);

   localparam logic [1:0] ST_KEY    = 2'd0;
   localparam logic [1:0] ST_LEN_LO = 2'd1;
   localparam logic [1:0] ST_LEN_HI = 2'd2;
   localparam logic [1:0] ST_BODY   = 2'd3;

   logic [1:0]  state_ff, state_in;
   logic [7:0]  key_ff, key_in;
   logic [15:0] length_ff, length_in;
   logic [15:0] index_ff, index_in;
   logic [15:0] max_body_ff;

   logic [15:0] total;
   logic [15:0] body;
   logic [15:0] lim;
   logic [16:0] index_next;
   logic        last;
   logic [7:0]  pad;
   logic [7:0]  dec;

   assign load = beat.valid && out_ready;

   assign total      = {beat.rx_byte, length_ff[7:0]};
   assign body       = total - HEADER_BYTES;
   assign lim        = (length_ff > DECRYPT_CLAMP) ? DECRYPT_CLAMP : length_ff;
   assign index_next = {1'b0, index_ff} + 17'd1;
   assign last       = index_next >= {1'b0, length_ff};
   assign pad        = key_ff ^ 8'(lim - index_ff);
   assign dec        = (beat.rx_byte ^ pad) - (index_ff[7:0] ^ key_ff);

   always_comb begin
      state_in            = state_ff;
      key_in              = key_ff;
      length_in           = length_ff;
      index_in            = index_ff;
      rsp.status          = STATUS_HEADER;
      rsp.data_byte       = 8'd0;
      rsp.last_of_message = 1'b0;
      rsp.message_key     = key_ff;
      rsp.message_length  = 16'd0;
      unique case (state_ff)
         ST_KEY: begin
            key_in          = beat.rx_byte;
            rsp.message_key = beat.rx_byte;
            state_in        = ST_LEN_LO;
         end
         ST_LEN_LO: begin
            length_in = {8'd0, beat.rx_byte};
            state_in  = ST_LEN_HI;
         end
         ST_LEN_HI: begin
            length_in          = body;
            index_in           = 16'd0;
            rsp.message_length = body;
            state_in           = ST_KEY;
            if (total == HEADER_BYTES) begin
               rsp.status          = STATUS_EMPTY;
               rsp.last_of_message = 1'b1;
            end else if (total < HEADER_BYTES || body > max_body_ff) begin
               rsp.status = STATUS_LENGTH_ERROR;
            end else begin
               state_in = ST_BODY;
            end
         end
         ST_BODY: begin
            rsp.status          = STATUS_BODY;
            rsp.message_length  = length_ff;
            rsp.last_of_message = last;
            rsp.data_byte       = (key_ff != 8'd0 && index_ff < lim) ? dec : beat.rx_byte;
            if (last) begin
               state_in = ST_KEY;
               index_in = 16'd0;
            end else begin
               index_in = index_next[15:0];
            end
         end
         default: begin
            state_in = ST_KEY;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_KEY;
         key_ff      <= 8'd0;
         length_ff   <= 16'd0;
         index_ff    <= 16'd0;
         max_body_ff <= MAX_BODY_RESET;
      end else begin
         if (load) begin
            state_ff  <= state_in;
            key_ff    <= key_in;
            length_ff <= length_in;
            index_ff  <= index_in;
         end
         if (csr_wr_en) begin
            max_body_ff <= csr_wr_data;
         end
      end
   end

endmodule

### rtl/frd_out_stage.sv
// ----------------------------------------------------------------------------
// frd_out_stage
// Result register: holds one result beat until the downstream side takes it.
// ----------------------------------------------------------------------------
module frd_out_stage
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        load,
   input  rsp_type     rsp,
   output logic        out_ready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,
   output logic        rsp_tlast
);

   logic    valid_ff, valid_in;
   rsp_type rsp_ff, rsp_in;

   assign out_ready = !valid_ff || rsp_tready;

   always_comb begin
      valid_in = valid_ff;
      rsp_in   = rsp_ff;
      if (load) begin
         valid_in = 1'b1;
         rsp_in   = rsp;
      end else if (rsp_tready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = {rsp_ff.message_length, rsp_ff.message_key, rsp_ff.data_byte};
   assign rsp_tuser  = rsp_ff.status;
   assign rsp_tlast  = rsp_ff.last_of_message;

endmodule

### rtl/frame_receiver_decrypt.sv
// Path: an accepted input beat is held in the input register, decoded by the core
// and then held in the result register, which drives the result port.
// Throughput: one beat per cycle while results are taken; the input and result
// registers each hold one beat, so a stalled result still lets one more beat in.
// Reset: synchronous, active high; clears the header parser to the key byte and
// sets max_body_length to 8192.
// ----------------------------------------------------------------------------
// frame_receiver_decrypt
// Frame receiver that parses a three-byte header and decrypts the body in flight.
// ----------------------------------------------------------------------------
module frame_receiver_decrypt
   import frd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [7:0] data_byte, [15:8] message_key,
                                     // [31:16] message_length
   output logic [1:0]  rsp_tuser,    // [1:0] status
   output logic        rsp_tlast
);

   in_beat_type beat;
   rsp_type     rsp;
   logic        out_ready;
   logic        load;

   frd_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .out_ready  (out_ready),
      .beat       (beat)
   );

   frd_core u_core (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .beat        (beat),
      .out_ready   (out_ready),
      .load        (load),
      .rsp         (rsp)
   );

   frd_out_stage u_out_stage (
      .clock      (clock),
      .reset      (reset),
      .load       (load),
      .rsp        (rsp),
      .out_ready  (out_ready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

### rtl/frd_checker.sv
// ----------------------------------------------------------------------------
// frd_checker
// Port-level checks on the result stream of the frame receiver.
// ----------------------------------------------------------------------------
module frd_checker
   import frd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic [1:0]  rsp_tuser,
   input logic        rsp_tlast
);

   a_reset_idle : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("Result beat valid right after reset.");

   a_stall_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser)
         && $stable(rsp_tlast))
      else $error("Stalled result beat changed.");

   a_last_kind : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tlast |-> rsp_tuser == STATUS_BODY || rsp_tuser == STATUS_EMPTY)
      else $error("Last marker on a beat that ends no message.");

   a_empty_done : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == STATUS_EMPTY |-> rsp_tlast && rsp_tdata[31:16] == 16'd0)
      else $error("Empty message beat without last marker or with a length.");

   a_data_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != STATUS_BODY |-> rsp_tdata[7:0] == 8'd0)
      else $error("Data byte set on a beat that carries no body byte.");

endmodule

bind frame_receiver_decrypt frd_checker u_frd_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

### sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the frame receiver with in-flight decryption.
// A queue of stream bytes feeds a driver. A monitor predicts the result beat
// of every accepted byte and checks the result beats in order. The run goes
// through directed frames and then random frames under several body limits.
// ----------------------------------------------------------------------------
module tb;
   import frd_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en = 1'b0;
   logic [15:0] csr_wr_data = '0;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   logic [7:0]  rx_stream_q[$];
   rsp_type     expected_rsp_q[$];
   int          queued_items = 0;
   int          mismatch_count = 0;
   int          cycle_count = 0;
   int          send_gap = 0;
   int          sink_gap = 0;
   int          stall_left = 0;
   logic        stall_go = 1'b0;
   logic        calm = 1'b0;

   logic [15:0] body_limit = MAX_BODY_RESET;
   logic        in_body = 1'b0;
   logic [1:0]  hdr_count = '0;
   logic [7:0]  key_q = '0;
   logic [15:0] len_q = '0;
   logic [15:0] idx_q = '0;

   frame_receiver_decrypt DUT (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .rsp_tlast   (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type decode_rx_byte(input logic [7:0] b);
      rsp_type     r;
      logic [15:0] total;
      logic [15:0] body;
      logic [15:0] lim;
      logic [15:0] distance;
      logic [16:0] next_idx;
      logic [7:0]  d;
      r = '0;
      if (!in_body) begin
         case (hdr_count)
            2'd0: begin
               key_q = b;
               hdr_count = 2'd1;
               r.status = STATUS_HEADER;
               r.message_key = b;
            end
            2'd1: begin
               len_q = {8'h00, b};
               hdr_count = 2'd2;
               r.status = STATUS_HEADER;
               r.message_key = key_q;
            end
            default: begin
               total = {b, len_q[7:0]};
               body = total - HEADER_BYTES;
               hdr_count = 2'd0;
               len_q = body;
               idx_q = '0;
               r.message_key = key_q;
               r.message_length = body;
               if (total == HEADER_BYTES) begin
                  r.status = STATUS_EMPTY;
                  r.last_of_message = 1'b1;
               end else if (total < HEADER_BYTES || body > body_limit) begin
                  r.status = STATUS_LENGTH_ERROR;
               end else begin
                  in_body = 1'b1;
                  r.status = STATUS_HEADER;
               end
            end
         endcase
      end else begin
         lim = (len_q > DECRYPT_CLAMP) ? DECRYPT_CLAMP : len_q;
         d = b;
         if (key_q != 8'h00 && idx_q < lim) begin
            distance = lim - idx_q;
            d = b ^ key_q ^ distance[7:0];
            d = d - (idx_q[7:0] ^ key_q);
         end
         next_idx = {1'b0, idx_q} + 17'd1;
         r.status = STATUS_BODY;
         r.data_byte = d;
         r.last_of_message = (next_idx >= {1'b0, len_q});
         r.message_key = key_q;
         r.message_length = len_q;
         if (r.last_of_message) begin
            in_body = 1'b0;
            hdr_count = 2'd0;
            idx_q = '0;
         end else begin
            idx_q = next_idx[15:0];
         end
      end
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("tb: mismatch in %s: got %0h, expected %0h", what, got, want);
      mismatch_count++;
   endtask

   // Driver for the byte stream.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         send_gap <= 0;
      end else if (!req_tvalid || req_tready) begin
         if (send_gap != 0) begin
            req_tvalid <= 1'b0;
            send_gap <= send_gap - 1;
         end else if (!calm && $urandom_range(0, 5) == 0) begin
            req_tvalid <= 1'b0;
            send_gap <= $urandom_range(0, 2);
         end else if (rx_stream_q.size() != 0) begin
            req_tvalid <= 1'b1;
            req_tdata <= rx_stream_q.pop_front();
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         stall_left <= 0;
      end else if (stall_go) begin
         stall_left <= 150;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         sink_gap <= 0;
      end else if (stall_go || stall_left != 0) begin
         rsp_tready <= 1'b0;
      end else if (sink_gap != 0) begin
         rsp_tready <= 1'b0;
         sink_gap <= sink_gap - 1;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
         rsp_tready <= 1'b0;
         sink_gap <= $urandom_range(0, 2);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Monitor: predicts each accepted byte, then checks each result beat.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (req_tvalid && req_tready)
            expected_rsp_q.push_back(decode_rx_byte(req_tdata));
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected beat", rsp_tdata, '0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_tuser != want.status)
                  report_mismatch("status", 32'(rsp_tuser), 32'(want.status));
               if (rsp_tdata[7:0] != want.data_byte)
                  report_mismatch("data_byte", 32'(rsp_tdata[7:0]), 32'(want.data_byte));
               if (rsp_tlast != want.last_of_message)
                  report_mismatch("last_of_message", 32'(rsp_tlast),
                                  32'(want.last_of_message));
               if (rsp_tdata[15:8] != want.message_key)
                  report_mismatch("message_key", 32'(rsp_tdata[15:8]),
                                  32'(want.message_key));
               if (rsp_tdata[31:16] != want.message_length)
                  report_mismatch("message_length", 32'(rsp_tdata[31:16]),
                                  32'(want.message_length));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   task automatic queue_frame(input logic [7:0] key, input logic [15:0] total,
                              input int body_bytes);
      rx_stream_q.push_back(key);
      rx_stream_q.push_back(total[7:0]);
      rx_stream_q.push_back(total[15:8]);
      for (int i = 0; i < body_bytes; i++)
         rx_stream_q.push_back(8'($urandom));
      queued_items += 3 + body_bytes;
   endtask

   function automatic logic [7:0] pick_key();
      int pick;
      pick = $urandom_range(0, 3);
      if (pick == 0)
         return 8'h00;
      if (pick == 1)
         return 8'hFF;
      return 8'($urandom);
   endfunction

   task automatic queue_random_frames(input int count);
      int          target;
      int          pick;
      int          body_n;
      int          cap;
      logic [15:0] total;
      target = queued_items + count;
      while (queued_items < target) begin
         pick = $urandom_range(0, 99);
         body_n = 0;
         cap = (body_limit < 24) ? int'(body_limit) : 24;
         if (pick < 12) begin
            total = HEADER_BYTES;
         end else if (pick < 25) begin
            if (body_limit < 16'd65532 && pick < 15)
               total = body_limit + 16'd4;
            else if (body_limit < 16'd65532 && pick < 20)
               total = 16'($urandom_range(int'(body_limit) + 1, 65532) + 3);
            else
               total = 16'($urandom_range(0, 2));
         end else if (body_limit == 0) begin
            total = 16'($urandom_range(4, 40));
         end else begin
            body_n = $urandom_range(1, cap);
            if (pick >= 95 && body_limit <= 64)
               body_n = int'(body_limit);
            total = 16'(body_n + 3);
         end
         queue_frame(pick_key(), total, body_n);
      end
   endtask

   task automatic settle();
      while (rx_stream_q.size() != 0 || req_tvalid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      body_limit = value;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      queue_frame(8'h00, 16'd5, 2);
      queue_frame(8'hFF, 16'd6, 3);
      queue_frame(8'h5A, HEADER_BYTES, 0);
      queue_frame(8'h80, 16'd0, 0);
      queue_frame(8'hFF, 16'd2, 0);
      queue_frame(8'h01, 16'hFFFF, 0);
      queue_frame(8'h7E, 16'd4, 1);
      settle();

      @(negedge clock);
      stall_go = 1'b1;
      @(negedge clock);
      stall_go = 1'b0;
      queue_random_frames(250);
      settle();

      write_limit(16'd0);
      @(negedge clock);
      queue_random_frames(100);
      settle();

      write_limit(16'hFFFF);
      @(negedge clock);
      queue_frame(8'hA5, 16'd703, 700);
      queue_frame(8'h00, 16'd303, 300);
      queue_random_frames(100);
      settle();

      write_limit(16'($urandom_range(1, 40)));
      @(negedge clock);
      queue_random_frames(200);
      settle();

      write_limit(MAX_BODY_RESET);
      @(negedge clock);
      calm = 1'b1;
      queue_random_frames(150);
      settle();

      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

### filelist.f
rtl/frd_pkg.sv
rtl/frd_in_stage.sv
rtl/frd_core.sv
rtl/frd_out_stage.sv
rtl/frame_receiver_decrypt.sv
rtl/frd_checker.sv
sim/tb.sv
